// ----- hdl/bprs_pkg.sv -----
// Shared types and constants for the bitmap priority ready scheduler.
package bprs_pkg;

    localparam int NUM_PRIORITIES_DEF = 32;
    localparam int NUM_THREADS_DEF    = 32;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_YIELD  = 2'd2,
        ACT_SWITCH = 2'd3
    } t_action;

    typedef struct packed {
        logic [1:0] action;
        logic [4:0] thread_id;
        logic [4:0] priority_req;
    } t_in_item;

    typedef struct packed {
        logic [4:0]  running_thread;
        logic        running_valid;
        logic [4:0]  running_priority;
        logic        switched;
        logic [4:0]  previous_thread;
        logic        previous_valid;
        logic [31:0] ready_bits;
        logic        status;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // capture the input item
        logic execute;  // perform the captured action, register the result
    } t_dp_cmd;

endpackage

// ----- hdl/bprs_datapath.sv -----
// Queue arrays, ready mask, running thread and combinational action logic.
module bprs_datapath #(
    parameter int NUM_PRIORITIES = bprs_pkg::NUM_PRIORITIES_DEF,
    parameter int NUM_THREADS    = bprs_pkg::NUM_THREADS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bprs_pkg::t_dp_cmd  i_cmd,
    input  bprs_pkg::t_in_item i_item,
    output bprs_pkg::t_out_item o_result
);
    import bprs_pkg::*;

    localparam int TW = (NUM_THREADS > 1) ? $clog2(NUM_THREADS) : 1;
    localparam int PW = (NUM_PRIORITIES > 1) ? $clog2(NUM_PRIORITIES) : 1;

    t_in_item r_item;

    logic [TW-1:0] r_head [NUM_PRIORITIES];
    logic [TW-1:0] r_tail [NUM_PRIORITIES];
    logic [TW-1:0] r_next [NUM_THREADS];
    logic [TW-1:0] r_prev [NUM_THREADS];
    logic [PW-1:0] r_tprio [NUM_THREADS];
    logic [NUM_THREADS-1:0]    r_queued;
    logic [NUM_PRIORITIES-1:0] r_mask;
    logic [TW-1:0] r_cur;
    logic          r_cur_v;
    logic [PW-1:0] r_cur_p;

    // Combinational next state (one action fully evaluated).
    logic [TW-1:0] n_head [NUM_PRIORITIES];
    logic [TW-1:0] n_tail [NUM_PRIORITIES];
    logic [TW-1:0] n_next [NUM_THREADS];
    logic [TW-1:0] n_prev [NUM_THREADS];
    logic [PW-1:0] n_tprio [NUM_THREADS];
    logic [NUM_THREADS-1:0]    n_queued;
    logic [NUM_PRIORITIES-1:0] n_mask;
    logic [TW-1:0] n_cur;
    logic          n_cur_v;
    logic [PW-1:0] n_cur_p;
    t_out_item     n_res;
    t_out_item     r_res;

    always_comb begin
        logic [TW-1:0] t, nx, pv, last;
        logic [PW-1:0] p;
        logic          hd, tl, in_rng, do_sw, found;
        logic [PW-1:0] sel_p;
        logic [TW-1:0] sel_t;
        n_head = r_head; n_tail = r_tail; n_next = r_next; n_prev = r_prev;
        n_tprio = r_tprio; n_queued = r_queued; n_mask = r_mask;
        n_cur = r_cur; n_cur_v = r_cur_v; n_cur_p = r_cur_p;
        n_res = '0;
        t = '0; nx = '0; pv = '0; last = '0; p = '0;
        hd = 1'b0; tl = 1'b0; do_sw = 1'b0; found = 1'b0;
        sel_p = '0; sel_t = '0;
        in_rng = (32'(r_item.thread_id) < NUM_THREADS);
        case (t_action'(r_item.action))
            ACT_INSERT: begin
                t = TW'(r_item.thread_id);
                p = PW'(r_item.priority_req);
                if (!in_rng || 32'(r_item.priority_req) >= NUM_PRIORITIES
                        || r_queued[t]) begin
                    n_res.status = 1'b1;
                end else begin
                    n_tprio[t] = p;
                    if (!r_mask[p]) begin
                        n_head[p] = t;
                    end else begin
                        last = r_tail[p];
                        n_next[last] = t;
                        n_prev[t] = last;
                    end
                    n_tail[p] = t;
                    n_mask[p] = 1'b1;
                    n_queued[t] = 1'b1;
                end
            end
            ACT_REMOVE: begin
                t = TW'(r_item.thread_id);
                if (!in_rng || !r_queued[t]) begin
                    n_res.status = 1'b1;
                end else begin
                    p = r_tprio[t];
                    hd = (r_head[p] == t);
                    tl = (r_tail[p] == t);
                    nx = r_next[t];
                    pv = r_prev[t];
                    if (hd && tl) begin
                        n_mask[p] = 1'b0;
                    end else begin
                        if (hd) n_head[p] = nx; else n_next[pv] = nx;
                        if (tl) n_tail[p] = pv; else n_prev[nx] = pv;
                    end
                    n_queued[t] = 1'b0;
                end
            end
            ACT_YIELD: begin
                if (!r_cur_v) begin
                    n_res.status = 1'b1;
                end else begin
                    t = r_cur;
                    do_sw = 1'b1;
                    if (r_queued[t]) begin
                        p = r_tprio[t];
                        hd = (r_head[p] == t);
                        tl = (r_tail[p] == t);
                        if (hd && tl) begin
                            do_sw = 1'b0;
                        end else if (!tl) begin
                            // Unlink then append at the tail; queue stays non-empty.
                            nx = r_next[t];
                            pv = r_prev[t];
                            if (hd) n_head[p] = nx; else n_next[pv] = nx;
                            n_prev[nx] = pv;
                            last = r_tail[p];
                            n_next[last] = t;
                            n_prev[t] = last;
                            n_tail[p] = t;
                        end
                    end
                end
            end
            default: do_sw = 1'b1;
        endcase

        if (do_sw) begin
            for (int i = NUM_PRIORITIES - 1; i >= 0; i--) begin
                if (n_mask[i]) begin
                    found = 1'b1;
                    sel_p = PW'(i);
                end
            end
            sel_t = n_head[sel_p];
            if (found && !(r_cur_v && r_cur == sel_t)) begin
                n_res.switched        = 1'b1;
                n_res.previous_thread = 5'(r_cur);
                n_res.previous_valid  = r_cur_v;
                n_cur   = sel_t;
                n_cur_v = 1'b1;
                n_cur_p = n_tprio[sel_t];
            end
        end
        n_res.running_thread   = 5'(n_cur);
        n_res.running_valid    = n_cur_v;
        n_res.running_priority = 5'(n_cur_p);
        n_res.ready_bits       = 32'(n_mask);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_item <= i_item;
        if (i_cmd.execute) begin
            r_head <= n_head; r_tail <= n_tail; r_next <= n_next;
            r_prev <= n_prev; r_tprio <= n_tprio; r_res <= n_res;
        end
        if (!i_rst_n) begin
            r_queued <= '0; r_mask <= '0;
            r_cur <= '0; r_cur_v <= 1'b0; r_cur_p <= '0;
        end else if (i_cmd.execute) begin
            r_queued <= n_queued; r_mask <= n_mask;
            r_cur <= n_cur; r_cur_v <= n_cur_v; r_cur_p <= n_cur_p;
        end
    end

    assign o_result = r_res;
endmodule

// ----- hdl/bprs_ctrl.sv -----
// Handshake controller: accept, execute, present the result.
module bprs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output bprs_pkg::t_dp_cmd o_cmd
);
    import bprs_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_OUT} t_state;
    t_state r_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            case (r_state)
                ST_IDLE: if (i_in_valid) r_state <= ST_EXEC;
                ST_EXEC: r_state <= ST_OUT;
                ST_OUT:  if (!i_out_stall) r_state <= ST_IDLE;
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_in_stall    = (r_state != ST_IDLE);
    assign o_out_valid   = (r_state == ST_OUT);
    assign o_cmd.load    = (r_state == ST_IDLE) && i_in_valid;
    assign o_cmd.execute = (r_state == ST_EXEC);
endmodule

// ----- hdl/bitmap_priority_ready_scheduler_core.sv -----
// Top level of the bitmap priority ready-queue scheduler.
//
//   Channel | Direction | Handshake              | Payload
//   input   | in        | i_in_valid/o_in_stall  | i_in_item  (t_in_item)
//   output  | out       | o_out_valid/i_out_stall| o_out_item (t_out_item)
//
// Each item is first captured; then the whole action (queue link update plus
// priority encode of the ready mask) is evaluated and written to the register
// arrays, and then the result is presented. The controller handles one item
// at a time.
// Reset is synchronous and active low; it clears the ready mask, the queued
// flags and the running thread. Queue head, tail and link arrays need no reset.
// An output stall holds the result and blocks the next input item.
module bitmap_priority_ready_scheduler_core #(
    parameter int NUM_PRIORITIES = bprs_pkg::NUM_PRIORITIES_DEF,
    parameter int NUM_THREADS    = bprs_pkg::NUM_THREADS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  bprs_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output bprs_pkg::t_out_item o_out_item
);
    import bprs_pkg::*;

    t_dp_cmd w_cmd;

    // The controller sequences capture, execute and result hand-off.
    bprs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd)
    );

    // The datapath holds all scheduler state and the result register.
    bprs_datapath #(
        .NUM_PRIORITIES (NUM_PRIORITIES),
        .NUM_THREADS    (NUM_THREADS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_item   (i_in_item),
        .o_result (o_out_item)
    );

    // An execute step is always followed by the result being shown.
    a_exec_then_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.execute |=> o_out_valid)
        else $error("execute not followed by output");

    // The input is never taken while a result is pending.
    a_no_load_when_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !w_cmd.load)
        else $error("load while result pending");

    // A switch always reports a running thread afterwards.
    a_switch_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.switched) |-> o_out_item.running_valid)
        else $error("switch without running thread");

    // An ignored action never reports a switch.
    a_status_no_switch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.status) |-> !o_out_item.switched)
        else $error("ignored action switched");
endmodule
